// ===== sv/column_melt_wipe_unit_macros.svh =====
// Assertion helpers for the melt wipe unit checker.
`ifndef COLUMN_MELT_WIPE_UNIT_MACROS_SVH
`define COLUMN_MELT_WIPE_UNIT_MACROS_SVH

// Same-cycle implication.
`define CMW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("column_melt_wipe_unit: property violated");

// Next-cycle implication.
`define CMW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("column_melt_wipe_unit: property violated");

`endif

// ===== sv/cmw_pkg.sv =====
package cmw_pkg;

  localparam int MAX_COLUMNS_DEF = 256;
  localparam int MAX_HEIGHT_DEF  = 1024;

  localparam int ACTION_W      = 2;
  localparam int RANDOM_W      = 31;
  localparam int COLUMN_W      = 8;
  localparam int ROW_W         = 10;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 11;
  localparam int NUM_COLUMNS_W = 9;
  localparam int HEIGHT_W      = 11;
  localparam int SEED_W        = 4;
  localparam int PAIR_W        = 8;
  localparam int PREV_W        = 5;
  localparam int QUEUE_DEPTH   = 2;

  localparam int SEED_FLOOR        = -15;
  localparam int GROW_LIMIT        = 16;
  localparam int HEIGHT_STEP_SHIFT = 4;

  localparam logic [NUM_COLUMNS_W-1:0] NUM_COLUMNS_RST = 9'd160;
  localparam logic [HEIGHT_W-1:0]      FRAME_ROWS_RST  = 11'd200;

  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_ROWS  = 2'd1;

  localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

  typedef enum logic [1:0] {
    KIND_INIT,
    KIND_TICK,
    KIND_QUERY,
    KIND_NOP
  } cmw_kind_t;

  typedef struct packed {
    cmw_kind_t           kind;
    logic [SEED_W-1:0]   seed;
    logic [1:0]          rem3;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
  } cmw_cmd_t;

  typedef struct packed {
    logic [NUM_COLUMNS_W-1:0] num_columns;
    logic [HEIGHT_W-1:0]      frame_rows;
  } cmw_cfg_t;

endpackage

// ===== sv/cmw_front.sv =====
module cmw_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cmw_pkg::ACTION_W-1:0]   in_action,
  input  logic [cmw_pkg::RANDOM_W-1:0]   in_random_value,
  input  logic [cmw_pkg::COLUMN_W-1:0]   in_column,
  input  logic [cmw_pkg::ROW_W-1:0]      in_row,
  output logic                           cmd_valid,
  output cmw_pkg::cmw_cmd_t              cmd,
  input  logic                           cmd_pop
);
  import cmw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // r mod 3: base-4 digits all weigh 1 mod 3.
  function automatic logic [1:0] rem3(input logic [RANDOM_W-1:0] r);
    logic [31:0] rx;
    logic [3:0]  grp [4];
    logic [5:0]  s;
    logic [3:0]  t;
    rx = 32'(r);
    s  = '0;
    for (int g = 0; g < 4; g++) begin
      grp[g] = '0;
      for (int k = 0; k < 4; k++) begin
        grp[g] = grp[g] + 4'(rx[(g * 8) + (k * 2) +: 2]);
      end
    end
    for (int g = 0; g < 4; g++) begin
      s = s + 6'(grp[g]);
    end
    t = 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
    if (t >= 4'd6) t = t - 4'd6;
    if (t >= 4'd3) t = t - 4'd3;
    return t[1:0];
  endfunction

  cmw_cmd_t         q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  cmw_cmd_t         entry;
  logic             push;
  logic             pop;

  always_comb begin
    entry.seed   = in_random_value[SEED_W-1:0];
    entry.rem3   = rem3(in_random_value);
    entry.column = in_column;
    entry.row    = in_row;
    case (in_action)
      ACT_INIT:  entry.kind = KIND_INIT;
      ACT_TICK:  entry.kind = KIND_TICK;
      ACT_QUERY: entry.kind = KIND_QUERY;
      default:   entry.kind = KIND_NOP;
    endcase
  end

  assign in_ready  = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// ===== sv/cmw_back.sv =====
module cmw_back #(
  parameter int MAX_COLUMNS = cmw_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_HEIGHT  = cmw_pkg::MAX_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmw_pkg::cmw_cfg_t         cfg,
  input  logic                      cmd_valid,
  input  cmw_pkg::cmw_cmd_t         cmd,
  output logic                      cmd_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_done_res,
  output logic                      out_use_end_screen,
  output logic [cmw_pkg::ROW_W-1:0] out_source_row
);
  import cmw_pkg::*;

  localparam int CIDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int H_W    = $clog2(MAX_HEIGHT + 1);
  localparam int OFF_W  = H_W + 1;
  localparam int QW     = ((OFF_W > ROW_W) ? OFF_W : ROW_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT2,
    ST_TICK,
    ST_QUERY
  } state_t;

  logic signed [OFF_W-1:0] mem [MAX_COLUMNS];
  logic signed [OFF_W-1:0] rdata_r;
  logic                    mem_we;
  logic [CIDX_W-1:0]       mem_waddr;
  logic [CIDX_W-1:0]       mem_raddr;
  logic signed [OFF_W-1:0] mem_wdata;

  state_t                   state_r, state_nxt;
  logic [PAIR_W-1:0]        ptr_r, ptr_nxt;
  logic signed [PREV_W-1:0] prev_r, prev_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic                     rd_pend_r, rd_pend_nxt;
  logic                     done_acc_r, done_acc_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [CIDX_W-1:0]        wb_idx_r, wb_idx_nxt;
  logic signed [OFF_W-1:0]  val_r, val_nxt;
  logic                     q_zero_r, q_zero_nxt;
  logic [ROW_W-1:0]         q_row_r, q_row_nxt;
  logic                     out_done_r, out_done_nxt;
  logic                     out_end_r, out_end_nxt;
  logic [ROW_W-1:0]         out_row_r, out_row_nxt;

  logic [CNT_W-1:0]        ncols;
  logic [H_W-1:0]          hgt;
  logic                    out_free;
  logic [PAIR_W:0]         c0;
  logic                    init_skip;
  logic                    has_second;
  logic signed [OFF_W-1:0] init_val;
  logic signed [OFF_W-1:0] seed_sum;
  logic                    col_in;
  logic signed [OFF_W-1:0] hs;
  logic signed [OFF_W-1:0] stp;
  logic signed [OFF_W-1:0] tick_val;
  logic                    tick_chg;
  logic signed [OFF_W-1:0] q_off;
  logic signed [QW-1:0]    q_offx;
  logic signed [QW-1:0]    q_rowx;
  logic                    q_end;
  logic [ROW_W-1:0]        q_src;

  assign ncols = (32'(cfg.num_columns) > MAX_COLUMNS) ? CNT_W'(MAX_COLUMNS)
                                                      : CNT_W'(cfg.num_columns);
  assign hgt   = (32'(cfg.frame_rows) > MAX_HEIGHT) ? H_W'(MAX_HEIGHT)
                                                    : H_W'(cfg.frame_rows);

  // init: seed value for the pair at the pointer
  assign c0         = {ptr_r, 1'b0};
  assign init_skip  = (32'(c0) >= 32'(ncols));
  assign has_second = ((32'(c0) + 32'd1) < MAX_COLUMNS);
  assign col_in     = (32'(cmd.column) < 32'(ncols)) && (32'(cmd.column) < MAX_COLUMNS);

  always_comb begin
    seed_sum = OFF_W'(prev_r) + $signed(OFF_W'(cmd.rem3)) - OFF_W'(1);
    if (ptr_r == '0) begin
      init_val = -$signed(OFF_W'(cmd.seed));
    end else if (seed_sum < OFF_W'(SEED_FLOOR)) begin
      init_val = OFF_W'(SEED_FLOOR);
    end else if (seed_sum > OFF_W'(0)) begin
      init_val = '0;
    end else begin
      init_val = seed_sum;
    end
  end

  // tick: one column update from the read data
  always_comb begin
    hs       = $signed({1'b0, hgt});
    stp      = $signed({1'b0, H_W'(hgt >> HEIGHT_STEP_SHIFT)});
    tick_chg = 1'b1;
    if (rdata_r < OFF_W'(0)) begin
      tick_val = rdata_r + OFF_W'(1);
    end else if (rdata_r < OFF_W'(GROW_LIMIT)) begin
      tick_val = rdata_r + rdata_r + OFF_W'(1);
    end else if (rdata_r < hs) begin
      if ((hs - rdata_r) < stp) begin
        stp = hs - rdata_r;
      end
      tick_val = rdata_r + stp;
    end else begin
      tick_val = rdata_r;
      tick_chg = 1'b0;
    end
  end

  // query: source screen and row
  always_comb begin
    q_off = q_zero_r ? '0 : rdata_r;
    if (q_off < OFF_W'(0)) begin
      q_off = '0;
    end
    q_offx = QW'(q_off);
    q_rowx = $signed(QW'(q_row_r));
    q_end  = (q_rowx < q_offx);
    q_src  = q_end ? q_row_r : ROW_W'(q_rowx - q_offx);
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    prev_nxt      = prev_r;
    idx_nxt       = idx_r;
    rd_pend_nxt   = rd_pend_r;
    done_acc_nxt  = done_acc_r;
    out_valid_nxt = out_valid_r;
    wb_idx_nxt    = wb_idx_r;
    val_nxt       = val_r;
    q_zero_nxt    = q_zero_r;
    q_row_nxt     = q_row_r;
    out_done_nxt  = out_done_r;
    out_end_nxt   = out_end_r;
    out_row_nxt   = out_row_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    cmd_pop       = 1'b0;
    out_free      = !out_valid_r || out_ready;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            KIND_INIT: begin
              out_valid_nxt = 1'b1;
              out_done_nxt  = 1'b0;
              out_end_nxt   = 1'b0;
              out_row_nxt   = '0;
              if (!init_skip) begin
                mem_we    = 1'b1;
                mem_waddr = CIDX_W'(c0);
                mem_wdata = init_val;
                prev_nxt  = PREV_W'(init_val);
                ptr_nxt   = ptr_r + 1'b1;
                if (has_second) begin
                  state_nxt  = ST_INIT2;
                  wb_idx_nxt = CIDX_W'(32'(c0) + 32'd1);
                  val_nxt    = init_val;
                end
              end
            end
            KIND_TICK: begin
              if (ncols == '0) begin
                out_valid_nxt = 1'b1;
                out_done_nxt  = 1'b1;
                out_end_nxt   = 1'b0;
                out_row_nxt   = '0;
                ptr_nxt       = '0;
              end else begin
                state_nxt    = ST_TICK;
                idx_nxt      = '0;
                rd_pend_nxt  = 1'b0;
                done_acc_nxt = 1'b1;
              end
            end
            KIND_QUERY: begin
              mem_raddr  = CIDX_W'(cmd.column);
              q_zero_nxt = !col_in;
              q_row_nxt  = cmd.row;
              state_nxt  = ST_QUERY;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_done_nxt  = 1'b0;
              out_end_nxt   = 1'b0;
              out_row_nxt   = '0;
            end
          endcase
        end
      end
      ST_INIT2: begin
        mem_we    = 1'b1;
        mem_waddr = wb_idx_r;
        mem_wdata = val_r;
        state_nxt = ST_IDLE;
      end
      ST_TICK: begin
        rd_pend_nxt = 1'b0;
        if (idx_r < ncols) begin
          mem_raddr   = idx_r[CIDX_W-1:0];
          idx_nxt     = idx_r + 1'b1;
          rd_pend_nxt = 1'b1;
          wb_idx_nxt  = idx_r[CIDX_W-1:0];
        end
        if (rd_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wb_idx_r;
          mem_wdata = tick_val;
          if (tick_chg) begin
            done_acc_nxt = 1'b0;
          end
          if (idx_r == ncols) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_done_nxt  = done_acc_r && !tick_chg;
            out_end_nxt   = 1'b0;
            out_row_nxt   = '0;
            if (done_acc_r && !tick_chg) begin
              ptr_nxt = '0;
            end
          end
        end
      end
      ST_QUERY: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_done_nxt  = 1'b0;
        out_end_nxt   = q_end;
        out_row_nxt   = q_src;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      prev_r      <= '0;
      idx_r       <= '0;
      rd_pend_r   <= 1'b0;
      done_acc_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      prev_r      <= prev_nxt;
      idx_r       <= idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      done_acc_r  <= done_acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wb_idx_r   <= wb_idx_nxt;
    val_r      <= val_nxt;
    q_zero_r   <= q_zero_nxt;
    q_row_r    <= q_row_nxt;
    out_done_r <= out_done_nxt;
    out_end_r  <= out_end_nxt;
    out_row_r  <= out_row_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign out_valid          = out_valid_r;
  assign out_done_res       = out_done_r;
  assign out_use_end_screen = out_end_r;
  assign out_source_row     = out_row_r;

endmodule

// ===== sv/column_melt_wipe_unit.sv =====
// Melt wipe column engine: one signed slide offset per column, held in a single
// memory with one write and one registered read port. Items enter a two-beat
// command queue and run one at a time behind it. An init writes the first
// column of the pair at the pointer, if it is in use, and then, in ST_INIT2,
// the second; a pixel query reads the offset and answers from ST_QUERY; and a
// tick reads, updates and writes back one column per cycle through the offset
// memory. Offsets come up undefined: seed every column in use with init beats
// before ticking or querying. Change the registers only while the unit is idle.
module column_melt_wipe_unit #(
  parameter int MAX_COLUMNS = cmw_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_HEIGHT  = cmw_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cmw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cmw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cmw_pkg::ACTION_W-1:0]    in_action,
  input  logic [cmw_pkg::RANDOM_W-1:0]    in_random_value,
  input  logic [cmw_pkg::COLUMN_W-1:0]    in_column,
  input  logic [cmw_pkg::ROW_W-1:0]       in_row,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_done_res,
  output logic                            out_use_end_screen,
  output logic [cmw_pkg::ROW_W-1:0]       out_source_row
);
  import cmw_pkg::*;

  cmw_cfg_t cfg_r, cfg_nxt;
  logic     cmd_valid;
  logic     cmd_pop;
  cmw_cmd_t cmd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_COLUMNS: cfg_nxt.num_columns = cfg_wdata[NUM_COLUMNS_W-1:0];
        CFG_FRAME_ROWS:  cfg_nxt.frame_rows  = cfg_wdata[HEIGHT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_columns <= NUM_COLUMNS_RST;
      cfg_r.frame_rows  <= FRAME_ROWS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cmw_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_random_value (in_random_value),
    .in_column       (in_column),
    .in_row          (in_row),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  cmw_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_HEIGHT  (MAX_HEIGHT)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .cmd_valid          (cmd_valid),
    .cmd                (cmd),
    .cmd_pop            (cmd_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_done_res       (out_done_res),
    .out_use_end_screen (out_use_end_screen),
    .out_source_row     (out_source_row)
  );

endmodule

// ===== sv/cmw_checker.sv =====
`include "column_melt_wipe_unit_macros.svh"

module cmw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_done_res,
  input logic                            out_use_end_screen,
  input logic [cmw_pkg::ROW_W-1:0]       out_source_row
);
  import cmw_pkg::*;

  // beats taken in but not yet answered
  logic [2:0]       pend_r;
  logic             in_acc;
  logic             out_acc;
  logic             out_stall;
  logic             done_clean;
  logic [ROW_W+1:0] out_pay;

  assign in_acc     = in_valid && in_ready;
  assign out_acc    = out_valid && out_ready;
  assign out_stall  = out_valid && !out_ready;
  assign done_clean = !out_use_end_screen && (out_source_row == '0);
  assign out_pay    = {out_done_res, out_use_end_screen, out_source_row};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  `CMW_ASSERT_IMP(a_no_orphan_result, clk, rst_n, out_valid, pend_r != 3'd0)
  `CMW_ASSERT_IMP(a_pending_bound, clk, rst_n, 1'b1, pend_r <= 3'd3)
  `CMW_ASSERT_IMP(a_done_excl, clk, rst_n, out_valid && out_done_res, done_clean)
  `CMW_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_pay))

endmodule

bind column_melt_wipe_unit cmw_checker u_cmw_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_done_res       (out_done_res),
  .out_use_end_screen (out_use_end_screen),
  .out_source_row     (out_source_row)
);

// ===== sim/tb_column_melt_wipe_unit.sv =====
module tb_column_melt_wipe_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cmw_pkg::*;

  localparam logic [ACTION_W-1:0]    ACT_UNKNOWN = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int CFG_SETTLE     = 8;
  localparam int END_QUIET      = 300;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_REPORTS    = 10;
  localparam int NUM_PHASES     = 12;

  typedef struct packed {
    logic             done;
    logic             use_end;
    logic [ROW_W-1:0] src_row;
  } wipe_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ACTION_W-1:0]    in_action = '0;
  logic [RANDOM_W-1:0]    in_random_value = '0;
  logic [COLUMN_W-1:0]    in_column = '0;
  logic [ROW_W-1:0]       in_row = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_done_res;
  logic                   out_use_end_screen;
  logic [ROW_W-1:0]       out_source_row;

  column_melt_wipe_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_random_value    (in_random_value),
    .in_column          (in_column),
    .in_row             (in_row),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_done_res       (out_done_res),
    .out_use_end_screen (out_use_end_screen),
    .out_source_row     (out_source_row)
  );

  // predicted wipe state
  int                       col_offset [MAX_COLUMNS_DEF];
  bit                       col_seeded [MAX_COLUMNS_DEF];
  logic [PAIR_W-1:0]        pair_ptr = '0;
  int                       last_pair_offset = 0;
  logic [NUM_COLUMNS_W-1:0] ncols_reg = NUM_COLUMNS_RST;
  logic [HEIGHT_W-1:0]      height_reg = FRAME_ROWS_RST;

  wipe_result_t wipe_results_q[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  bit reseed_pending = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int cols_in_use();
    return (ncols_reg > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(ncols_reg);
  endfunction

  function automatic int height_in_use();
    return (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(height_reg);
  endfunction

  function automatic bit all_seeded();
    int n;
    n = cols_in_use();
    for (int i = 0; i < n; i++) begin
      if (!col_seeded[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void seed_pair(input logic [RANDOM_W-1:0] r);
    int c0;
    int v;
    c0 = int'(pair_ptr) * 2;
    if (c0 >= cols_in_use()) return;
    if (pair_ptr == '0) begin
      v = -int'(r[3:0]);
    end else begin
      v = last_pair_offset + int'(r % 3) - 1;
      if (v < SEED_FLOOR) v = SEED_FLOOR;
      if (v > 0) v = 0;
    end
    col_offset[c0] = v;
    col_seeded[c0] = 1'b1;
    if (c0 + 1 < MAX_COLUMNS_DEF) begin
      col_offset[c0 + 1] = v;
      col_seeded[c0 + 1] = 1'b1;
    end
    last_pair_offset = v;
    pair_ptr = pair_ptr + 1'b1;
  endfunction

  function automatic bit advance_columns();
    int n;
    int h;
    int y;
    int step;
    bit done;
    n = cols_in_use();
    h = height_in_use();
    done = 1'b1;
    for (int i = 0; i < n; i++) begin
      y = col_offset[i];
      if (y < 0) begin
        col_offset[i] = y + 1;
        done = 1'b0;
      end else if (y < GROW_LIMIT) begin
        col_offset[i] = y + y + 1;
        done = 1'b0;
      end else if (y < h) begin
        step = h / 16;
        if (h - y < step) step = h - y;
        col_offset[i] = y + step;
        done = 1'b0;
      end
    end
    if (done) pair_ptr = '0;
    return done;
  endfunction

  function automatic wipe_result_t predict_wipe_result(input logic [ACTION_W-1:0] action,
                                                       input logic [RANDOM_W-1:0] r,
                                                       input logic [COLUMN_W-1:0] col,
                                                       input logic [ROW_W-1:0]    row);
    wipe_result_t res;
    int off;
    res = '0;
    case (action)
      ACT_INIT: begin
        seed_pair(r);
      end
      ACT_TICK: begin
        res.done = advance_columns();
      end
      ACT_QUERY: begin
        off = (int'(col) < cols_in_use()) ? col_offset[col] : 0;
        if (off < 0) off = 0;
        if (int'(row) < off) begin
          res.use_end = 1'b1;
          res.src_row = row;
        end else begin
          res.src_row = ROW_W'(int'(row) - off);
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic send_item(input logic [ACTION_W-1:0] action,
                           input logic [RANDOM_W-1:0] r,
                           input logic [COLUMN_W-1:0] col,
                           input logic [ROW_W-1:0]    row,
                           output wipe_result_t       res);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid        <= 1'b1;
    in_action       <= action;
    in_random_value <= r;
    in_column       <= col;
    in_row          <= row;
    do @(posedge clk); while (!in_ready);
    res = predict_wipe_result(action, r, col, row);
    wipe_results_q.push_back(res);
  endtask

  // picks a beat that never touches an unseeded column
  task automatic send_melt_item();
    int n;
    int pick;
    int near;
    logic [ACTION_W-1:0] action;
    logic [RANDOM_W-1:0] r;
    logic [COLUMN_W-1:0] col;
    logic [ROW_W-1:0]    row;
    wipe_result_t        res;
    n = cols_in_use();
    r = RANDOM_W'($urandom());
    col = COLUMN_W'($urandom());
    row = ROW_W'($urandom());
    if (reseed_pending && int'(pair_ptr) * 2 >= n) reseed_pending = 1'b0;
    if (!all_seeded() || reseed_pending) begin
      action = ACT_INIT;
    end else begin
      pick = $urandom_range(99);
      if (pick < 50) action = ACT_QUERY;
      else if (pick < 80) action = ACT_TICK;
      else if (pick < 90) action = ACT_INIT;
      else action = ACT_UNKNOWN;
    end
    if (action == ACT_QUERY) begin
      if ($urandom_range(4) != 0) col = COLUMN_W'($urandom_range(n - 1));
      if ($urandom_range(1) != 0) begin
        near = (int'(col) < n) ? col_offset[col] : 0;
        near = near + int'($urandom_range(4)) - 2;
        if (near < 0) near = 0;
        if (near > 1023) near = 1023;
        row = ROW_W'(near);
      end
    end
    send_item(action, r, col, row, res);
    if (action == ACT_TICK && res.done) reseed_pending = ($urandom_range(3) != 0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (wipe_results_q.size() != 0);
  endtask

  task automatic set_config(input int n_val, input int h_val);
    logic [CFG_DATA_W-1:0] ncols_word;
    ncols_word = CFG_DATA_W'($urandom());
    ncols_word[NUM_COLUMNS_W-1:0] = NUM_COLUMNS_W'(n_val);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NUM_COLUMNS;
    cfg_wdata <= ncols_word;
    @(posedge clk);
    cfg_index <= CFG_FRAME_ROWS;
    cfg_wdata <= CFG_DATA_W'(h_val);
    @(posedge clk);
    cfg_index <= CFG_SPARE_A;
    cfg_wdata <= CFG_DATA_W'($urandom());
    @(posedge clk);
    cfg_index <= CFG_SPARE_B;
    cfg_wdata <= CFG_DATA_W'($urandom());
    @(posedge clk);
    cfg_we <= 1'b0;
    ncols_reg  = ncols_word[NUM_COLUMNS_W-1:0];
    height_reg = HEIGHT_W'(h_val);
  endtask

  task automatic test_directed_cases();
    wipe_result_t res;
    gap_pct   = 0;
    stall_pct = 0;
    // reset config, column outside the 160 in use
    send_item(ACT_QUERY, '1, 8'hFF, 10'h3FF, res);
    send_item(ACT_UNKNOWN, '1, '1, '1, res);
    drain_results();
    set_config(2, 32);
    send_item(ACT_INIT, 31'h7FFF_FFF0, '0, '0, res);
    send_item(ACT_INIT, 31'h7FFF_FFFF, '1, '1, res);
    send_item(ACT_QUERY, '0, 8'd1, 10'd0, res);
    repeat (3) send_item(ACT_TICK, '0, '0, '0, res);
    send_item(ACT_QUERY, '0, 8'd0, 10'd6, res);
    send_item(ACT_QUERY, '0, 8'd1, 10'd7, res);
    repeat (3) send_item(ACT_TICK, '0, '0, '0, res);
    send_item(ACT_QUERY, '0, 8'd0, 10'd1023, res);
    // all columns at full height: done, pointer rewinds
    send_item(ACT_TICK, '1, '1, '1, res);
    send_item(ACT_INIT, 31'h0000_000F, '0, '0, res);
    send_item(ACT_QUERY, '1, 8'd0, 10'd5, res);
    send_item(ACT_QUERY, '1, 8'd2, 10'd3, res);
    send_item(ACT_TICK, '0, '0, '0, res);
    drain_results();
  endtask

  task automatic test_backpressure();
    gap_pct   = 0;
    stall_pct = 0;
    hold_len  = HOLD_CYCLES;
    repeat (16) send_melt_item();
    drain_results();
  endtask

  task automatic test_melt_phases();
    int n_val;
    int h_val;
    int items;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          n_val = 2;
          h_val = 32;
        end
        1: begin
          n_val = 256;
          h_val = 1024;
        end
        2: begin
          n_val = 511;
          h_val = 2047;
        end
        3: begin
          n_val = 255;
          h_val = 33;
        end
        default: begin
          n_val = $urandom_range(48, 2);
          h_val = $urandom_range(1024, 32);
        end
      endcase
      case (p % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 78;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 78;
        end
        default: begin
          gap_pct   = 25;
          stall_pct = 25;
        end
      endcase
      drain_results();
      set_config(n_val, h_val);
      items = 80 + cols_in_use();
      repeat (items) send_melt_item();
    end
  endtask

  // result side: random stalls plus the long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    wipe_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (wipe_results_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result beat: done=%0d end=%0d row=%0d",
                   out_done_res, out_use_end_screen, out_source_row);
        mismatches++;
      end else begin
        exp_res = wipe_results_q.pop_front();
        if (exp_res.done !== out_done_res || exp_res.use_end !== out_use_end_screen ||
            exp_res.src_row !== out_source_row) begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch: exp done=%0d end=%0d row=%0d, got done=%0d end=%0d row=%0d",
                     exp_res.done, exp_res.use_end, exp_res.src_row,
                     out_done_res, out_use_end_screen, out_source_row);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_backpressure();
    test_melt_phases();
    drain_results();
    repeat (END_QUIET) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
